@@ hdl/rrq_pkg.sv @@
// Shared types and constants for the reference ring queue.
// Holds operation and status codes, controller states and the command struct.
// No dependencies.
package rrq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;

    localparam int unsigned KIND_W   = 3;
    localparam int unsigned ELEM_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned FILL_W   = 5;
    localparam int unsigned CFG_W    = 5;
    localparam int unsigned CNT_W    = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_TAKE      = 3'd0,
        KIND_PUT_TAIL  = 3'd1,
        KIND_PUT_HEAD  = 3'd2,
        KIND_PEEK      = 3'd3,
        KIND_FLUSH     = 3'd4,
        KIND_CLR_STATS = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_RESP = 2'd2
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // perform the captured operation
    } t_dp_cmd;

endpackage

@@ hdl/rrq_in_if.sv @@
// Input channel of the reference ring queue: valid/ready handshake with one item.
// No dependencies.
interface rrq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] element;

    modport source (output valid, output kind, output element, input ready);
    modport sink   (input valid, input kind, input element, output ready);
endinterface

@@ hdl/rrq_out_if.sv @@
// Result channel of the reference ring queue: valid/ready handshake with one item.
// No dependencies.
interface rrq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] element_out;
    logic [4:0]  fill_count;
    logic [4:0]  low_watermark;
    logic        is_full;
    logic        nonempty;
    logic [31:0] put_total;
    logic [31:0] take_total;
    logic [31:0] peek_total;
    logic [31:0] empty_total;
    logic [31:0] full_total;

    modport source (
        output valid, output status, output element_out, output fill_count,
        output low_watermark, output is_full, output nonempty, output put_total,
        output take_total, output peek_total, output empty_total, output full_total,
        input ready
    );
    modport sink (
        input valid, input status, input element_out, input fill_count,
        input low_watermark, input is_full, input nonempty, input put_total,
        input take_total, input peek_total, input empty_total, input full_total,
        output ready
    );
endinterface

@@ hdl/rrq_ctrl.sv @@
// Controller of the reference ring queue: accept, execute, respond.
// Depends on rrq_pkg.
module rrq_ctrl
    import rrq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: n_state = S_RESP;
            S_RESP: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: o_cmd.exec = 1'b1;
            S_RESP: o_out_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

@@ hdl/rrq_dp.sv @@
// Datapath of the reference ring queue: slot store, pointers, watermark, counters.
// Depends on rrq_pkg.
module rrq_dp
    import rrq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [ELEM_W-1:0]   i_element,
    input  logic                i_cfg_wr_en,
    input  logic [CFG_W-1:0]    i_cfg_wr_data,
    output logic [STATUS_W-1:0] o_status,
    output logic [ELEM_W-1:0]   o_element_out,
    output logic [FILL_W-1:0]   o_fill_count,
    output logic [FILL_W-1:0]   o_low_watermark,
    output logic                o_is_full,
    output logic                o_nonempty,
    output logic [CNT_W-1:0]    o_put_total,
    output logic [CNT_W-1:0]    o_take_total,
    output logic [CNT_W-1:0]    o_peek_total,
    output logic [CNT_W-1:0]    o_empty_total,
    output logic [CNT_W-1:0]    o_full_total
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CAP_W = $clog2(DEPTH + 1);
    localparam int unsigned NCNT  = 5;
    localparam int unsigned CNT_PUT   = 0;
    localparam int unsigned CNT_TAKE  = 1;
    localparam int unsigned CNT_PEEK  = 2;
    localparam int unsigned CNT_EMPTY = 3;
    localparam int unsigned CNT_FULL  = 4;

    logic [ELEM_W-1:0] r_mem [DEPTH];
    logic [ELEM_W-1:0] r_rd_data;

    logic [KIND_W-1:0] r_kind;
    logic [ELEM_W-1:0] r_elem;

    logic [CAP_W-1:0]  r_cap;
    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_tail;
    logic [CAP_W-1:0]  r_count;
    logic [CAP_W-1:0]  r_min;
    logic [CNT_W-1:0]  r_cnt [NCNT];
    t_status           r_status;
    logic              r_hit;

    logic [IDX_W-1:0]  n_head;
    logic [IDX_W-1:0]  n_tail;
    logic [CAP_W-1:0]  n_count;
    logic [CAP_W-1:0]  n_min;
    logic [CNT_W-1:0]  n_cnt [NCNT];
    t_status           n_status;
    logic              n_hit;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [CAP_W-1:0]  cfg_cap;

    logic [CAP_W-1:0]  head_inc;
    logic [CAP_W-1:0]  tail_inc;
    logic [IDX_W-1:0]  head_next;
    logic [IDX_W-1:0]  head_prev;
    logic [IDX_W-1:0]  tail_next;
    logic              q_full;
    logic              q_empty;
    logic [CAP_W-1:0]  free_after;

    // Ring arithmetic wraps at the configured capacity, not at DEPTH.
    assign head_inc  = CAP_W'(r_head) + CAP_W'(1);
    assign tail_inc  = CAP_W'(r_tail) + CAP_W'(1);
    assign head_next = (head_inc >= r_cap) ? '0 : IDX_W'(head_inc);
    assign tail_next = (tail_inc >= r_cap) ? '0 : IDX_W'(tail_inc);
    assign head_prev = (r_head == '0 || CAP_W'(r_head) >= r_cap)
                     ? IDX_W'(r_cap - CAP_W'(1)) : r_head - IDX_W'(1);
    assign q_full    = (r_count >= r_cap);
    assign q_empty   = (r_count == '0);
    assign free_after = r_cap - (r_count + CAP_W'(1));

    // Clamp the written capacity into 1..DEPTH.
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            cfg_cap = CAP_W'(1);
        end else if (32'(i_cfg_wr_data) > DEPTH) begin
            cfg_cap = CAP_W'(DEPTH);
        end else begin
            cfg_cap = CAP_W'(i_cfg_wr_data);
        end
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_min    = r_min;
        n_status = STATUS_OK;
        n_hit    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_tail;
        for (int k = 0; k < NCNT; k++) begin
            n_cnt[k] = r_cnt[k];
        end
        unique case (r_kind)
            KIND_TAKE: begin
                if (q_empty) begin
                    n_status         = STATUS_EMPTY;
                    n_cnt[CNT_EMPTY] = r_cnt[CNT_EMPTY] + CNT_W'(1);
                end else begin
                    n_hit           = 1'b1;
                    n_head          = head_next;
                    n_count         = r_count - CAP_W'(1);
                    n_cnt[CNT_TAKE] = r_cnt[CNT_TAKE] + CNT_W'(1);
                end
            end
            KIND_PUT_TAIL, KIND_PUT_HEAD: begin
                if (q_full) begin
                    n_status        = STATUS_FULL;
                    n_cnt[CNT_FULL] = r_cnt[CNT_FULL] + CNT_W'(1);
                end else begin
                    wr_en = 1'b1;
                    if (r_kind == KIND_PUT_TAIL) begin
                        wr_addr = r_tail;
                        n_tail  = tail_next;
                    end else begin
                        wr_addr = head_prev;
                        n_head  = head_prev;
                    end
                    n_count = r_count + CAP_W'(1);
                    if (r_min > free_after) n_min = free_after;
                    n_cnt[CNT_PUT] = r_cnt[CNT_PUT] + CNT_W'(1);
                end
            end
            KIND_PEEK: begin
                if (q_empty) begin
                    n_status         = STATUS_EMPTY;
                    n_cnt[CNT_EMPTY] = r_cnt[CNT_EMPTY] + CNT_W'(1);
                end else begin
                    n_hit           = 1'b1;
                    n_cnt[CNT_PEEK] = r_cnt[CNT_PEEK] + CNT_W'(1);
                end
            end
            KIND_FLUSH: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            KIND_CLR_STATS: begin
                for (int k = 0; k < NCNT; k++) begin
                    n_cnt[k] = '0;
                end
            end
            default: ;
        endcase
    end

    // Item capture and slot store; store contents are never reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_elem <= i_element;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[r_head];
            if (wr_en) r_mem[wr_addr] <= r_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_W'(DEPTH);
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_min    <= CAP_W'(DEPTH);
            r_status <= STATUS_OK;
            r_hit    <= 1'b0;
            for (int k = 0; k < NCNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            r_cap   <= cfg_cap;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_min   <= cfg_cap;
        end else if (i_cmd.exec) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_min    <= n_min;
            r_status <= n_status;
            r_hit    <= n_hit;
            for (int k = 0; k < NCNT; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    assign o_status        = r_status;
    assign o_element_out   = r_hit ? r_rd_data : '0;
    assign o_fill_count    = FILL_W'(r_count);
    assign o_low_watermark = FILL_W'(r_min);
    assign o_is_full       = (r_count == r_cap);
    assign o_nonempty      = (r_count != '0);
    assign o_put_total     = r_cnt[CNT_PUT];
    assign o_take_total    = r_cnt[CNT_TAKE];
    assign o_peek_total    = r_cnt[CNT_PEEK];
    assign o_empty_total   = r_cnt[CNT_EMPTY];
    assign o_full_total    = r_cnt[CNT_FULL];

endmodule

@@ hdl/reference_ring_queue_core.sv @@
// Sequencing: an accepted item is captured, executed in the execute state, and its result
//   is held valid in the respond state until taken; no new item is accepted meanwhile.
// The controller runs accept, execute and respond in turn, the slot store read being
//   registered.
// Reset (i_rst_n low, synchronous): queue empty, pointers zero, capacity DEPTH,
//   low watermark DEPTH, event counters zero. Slot contents are not cleared; no
//   clearing pass, so the block is ready in the first cycle after reset.
module reference_ring_queue_core
    import rrq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    rrq_in_if.sink           i_item,
    rrq_out_if.source        o_result
);

    t_dp_cmd dp_cmd;

    // Sequence each item through capture, execute and result hold.
    rrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (dp_cmd)
    );

    // Slot store, ring pointers, watermark and event counters. A capacity
    // write empties the queue and reloads the watermark; counters keep counting.
    rrq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_kind          (i_item.kind),
        .i_element       (i_item.element),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_status        (o_result.status),
        .o_element_out   (o_result.element_out),
        .o_fill_count    (o_result.fill_count),
        .o_low_watermark (o_result.low_watermark),
        .o_is_full       (o_result.is_full),
        .o_nonempty      (o_result.nonempty),
        .o_put_total     (o_result.put_total),
        .o_take_total    (o_result.take_total),
        .o_peek_total    (o_result.peek_total),
        .o_empty_total   (o_result.empty_total),
        .o_full_total    (o_result.full_total)
    );

endmodule

@@ hdl/rrq_checker.sv @@
// Port-level checks for reference_ring_queue_core, attached by bind.
// Depends on rrq_pkg.
module rrq_checker
    import rrq_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [ELEM_W-1:0]   i_element_out,
    input logic                i_is_full,
    input logic                i_nonempty
);

    // One item in flight: no new item while a result is pending.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    // Acceptance is followed by the execute state, with no result, and then the result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> (!i_out_valid ##1 i_out_valid))
        else $error("result latency is not two cycles");

    // Hold a stalled result steady until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_element_out)))
        else $error("stalled result changed");

    // A refused take or peek leaves the queue empty and returns no element.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == STATUS_EMPTY) |-> (!i_nonempty && i_element_out == '0))
        else $error("empty status with elements held");

    // A refused put means the queue is at capacity.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == STATUS_FULL) |-> (i_is_full && i_nonempty))
        else $error("full status while not full");

endmodule

bind reference_ring_queue_core rrq_checker u_rrq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_status      (o_result.status),
    .i_element_out (o_result.element_out),
    .i_is_full     (o_result.is_full),
    .i_nonempty    (o_result.nonempty)
);
